>>> sv/spvn_pkg.sv
package spvn_pkg;

    localparam int MAX_CONN  = 32;
    localparam int ADDR_W    = $clog2(MAX_CONN);
    localparam int CNT_W     = $clog2(MAX_CONN + 1);
    localparam int CID_W     = 24;
    localparam int Q_W       = 16;
    localparam int P_W       = Q_W + 1;
    localparam int N_W       = P_W + 2;
    localparam int DIV_STEPS = P_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS + 1);

    localparam logic [Q_W-1:0] THR_RESET = 16'd66;
    localparam logic [P_W-1:0] ONE_Q16   = 17'h10000;
    localparam logic [Q_W-1:0] SAT_Q16   = 16'hFFFF;

    typedef enum logic [2:0] {
        REQ_ADD    = 3'd0,
        REQ_REMOVE = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_EMIT   = 3'd3,
        REQ_BIAS   = 3'd4
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_FULL      = 3'd2,
        ST_ZERO_NORM = 3'd3,
        ST_NO_CONN   = 3'd4
    } t_status;

    typedef enum logic [4:0] {
        S_IDLE, S_ADD, S_RM_RD, S_RM_CHK, S_UP_RD, S_UP_CHK,
        S_EM_START, S_EM_RD, S_EM_DEST, S_PW_RD, S_PW_MUL,
        S_FIN_PT, S_FIN_PF, S_FIN_PU, S_NORM, S_DIV_CHK, S_DIV, S_OUT
    } t_state;

    typedef enum logic [1:0] {WR_NEW, WR_COPY, WR_SURV} t_wr_sel;
    typedef enum logic [2:0] {MUL_NONE, MUL_STEP, MUL_PT, MUL_PF, MUL_PU} t_mul_op;
    typedef enum logic [1:0] {VAL_ZERO, VAL_SURV, VAL_QUOT} t_val_sel;
    typedef enum logic [1:0] {CL_REQ, CL_DEST, CL_ZERO} t_cl_sel;
    typedef enum logic [1:0] {NUM_PF, NUM_PT, NUM_DIFF} t_num_sel;

    typedef struct packed {
        logic [CID_W-1:0] clause;
        logic             neg;
        logic [Q_W-1:0]   survey;
    } t_entry;

    typedef struct packed {
        logic              lat_req;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        t_wr_sel           wr_sel;
        logic              lat_dest;
        logic              prod_init;
        t_mul_op           mul_op;
        logic              use_excl;
        logic              norm_load;
        logic              div_start;
        t_num_sel          num_sel;
        logic              out_load;
        t_status           out_status;
        t_cl_sel           out_cl;
        t_val_sel          out_val;
        logic              out_changed;
        logic              out_last;
    } t_cmd;

    typedef struct packed {
        logic match;
        logic rd_neg;
        logic big;
        logic norm_zero;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

>>> sv/spvn_if.sv
interface spvn_req_if;
    import spvn_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       req_type;
    logic [CID_W-1:0] clause_id;
    logic             negative_list;
    logic [Q_W-1:0]   survey_value;

    modport source (output valid, req_type, clause_id, negative_list, survey_value,
                    input ready);
    modport sink (input valid, req_type, clause_id, negative_list, survey_value,
                  output ready);
endinterface

interface spvn_res_if;
    import spvn_pkg::*;
    logic             valid;
    logic             ready;
    logic [2:0]       status;
    logic [CID_W-1:0] target_clause;
    logic             target_negative;
    logic [Q_W-1:0]   result_value;
    logic             changed;
    logic             last;

    modport source (output valid, status, target_clause, target_negative, result_value,
                    changed, last, input ready);
    modport sink (input valid, status, target_clause, target_negative, result_value,
                  changed, last, output ready);
endinterface

>>> sv/survey_propagation_variable_node.sv
// One request is in work at a time, and output backpressure can hold it; the
// next is taken once the last word of the previous one sits in the output register.
// The shared multiplier and the 17-step divider, walked once per destination, set
// the emit time. Reset (synchronous, active low) empties the table, loads threshold 66.
module survey_propagation_variable_node
    import spvn_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [Q_W-1:0]  i_cfg_wdata,
    spvn_req_if.sink        i_req,
    spvn_res_if.source      o_res
);

    // The controller sequences each request over the connection table; the
    // datapath holds the table memory, the product registers, the divider and
    // the output word register.
    t_cmd  cmd;
    t_stat stat;

    spvn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .i_req_type (i_req.req_type),
        .i_stat     (stat),
        .o_ready    (i_req.ready),
        .o_cmd      (cmd)
    );

    spvn_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_clause_id       (i_req.clause_id),
        .i_negative_list   (i_req.negative_list),
        .i_survey_value    (i_req.survey_value),
        .i_cmd             (cmd),
        .i_out_ready       (o_res.ready),
        .o_stat            (stat),
        .o_out_valid       (o_res.valid),
        .o_status          (o_res.status),
        .o_target_clause   (o_res.target_clause),
        .o_target_negative (o_res.target_negative),
        .o_result_value    (o_res.result_value),
        .o_changed         (o_res.changed),
        .o_last            (o_res.last)
    );

endmodule

>>> sv/spvn_ctrl.sv
module spvn_ctrl
    import spvn_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_req_type,
    input  t_stat      i_stat,
    output logic       o_ready,
    output t_cmd       o_cmd
);

    t_state            r_state, n_state, r_ret, n_ret;
    logic [CNT_W-1:0]  r_i, n_i, r_j, n_j, r_w, n_w, r_cnt, n_cnt, r_k, n_k;
    logic              r_pass, n_pass, r_emit, n_emit;
    logic [1:0]        r_removed, n_removed;
    t_status           r_ost, n_ost;
    t_cl_sel           r_ocl, n_ocl;
    t_val_sel          r_oval, n_oval;
    logic              r_ochg, n_ochg, r_olast, n_olast;
    logic              accept;
    logic              emit_last;

    assign accept    = i_valid && (r_state == S_IDLE);
    assign emit_last = ((r_k + 1'b1) == r_cnt);

    always_comb begin
        n_state = r_state; n_ret = r_ret;
        n_i = r_i; n_j = r_j; n_w = r_w; n_cnt = r_cnt; n_k = r_k;
        n_pass = r_pass; n_emit = r_emit; n_removed = r_removed;
        n_ost = r_ost; n_ocl = r_ocl; n_oval = r_oval; n_ochg = r_ochg; n_olast = r_olast;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_ocl = CL_REQ; n_oval = VAL_ZERO; n_ochg = 1'b0;
                    n_olast = 1'b1; n_ret = S_IDLE; n_ost = ST_OK;
                    n_i = '0; n_j = '0; n_w = '0; n_k = '0; n_removed = '0;
                    n_pass = 1'b0; n_emit = 1'b0;
                    case (i_req_type)
                        REQ_ADD:    n_state = S_ADD;
                        REQ_REMOVE: n_state = S_RM_RD;
                        REQ_UPDATE: n_state = S_UP_RD;
                        REQ_EMIT: begin
                            n_emit  = 1'b1;
                            n_state = S_EM_START;
                        end
                        REQ_BIAS:   n_state = S_PW_RD;
                        default:    n_state = S_OUT;
                    endcase
                end
            end
            S_ADD: begin
                if (r_cnt == CNT_W'(MAX_CONN)) begin
                    n_ost = ST_FULL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
                n_state = S_OUT;
            end
            S_RM_RD: begin
                if (r_i == r_cnt) begin
                    n_cnt   = r_w;
                    n_ost   = (r_removed == 2'd1) ? ST_OK : ST_NOT_FOUND;
                    n_state = S_OUT;
                end else begin
                    n_state = S_RM_CHK;
                end
            end
            S_RM_CHK: begin
                if (i_stat.match) begin
                    if (r_removed != 2'd2) n_removed = r_removed + 1'b1;
                end else begin
                    n_w = r_w + 1'b1;
                end
                n_i     = r_i + 1'b1;
                n_state = S_RM_RD;
            end
            S_UP_RD: begin
                if (r_i == r_cnt) begin
                    n_ost   = ST_NOT_FOUND;
                    n_state = S_OUT;
                end else begin
                    n_state = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (i_stat.match) begin
                    n_oval  = VAL_SURV;
                    n_ochg  = i_stat.big;
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_UP_RD;
                end
            end
            S_EM_START: begin
                if (r_cnt == '0) begin
                    n_ost   = ST_NO_CONN;
                    n_ocl   = CL_ZERO;
                    n_state = S_OUT;
                end else begin
                    n_state = S_EM_RD;
                end
            end
            S_EM_RD: begin
                if (r_i == r_cnt) begin
                    if (!r_pass) begin
                        n_pass = 1'b1;
                        n_i    = '0;
                    end else begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_state = S_EM_DEST;
                end
            end
            S_EM_DEST: begin
                if (i_stat.rd_neg != r_pass) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_EM_RD;
                end else begin
                    n_j     = '0;
                    n_state = S_PW_RD;
                end
            end
            S_PW_RD:  n_state = (r_j == r_cnt) ? S_FIN_PT : S_PW_MUL;
            S_PW_MUL: begin
                n_j     = r_j + 1'b1;
                n_state = S_PW_RD;
            end
            S_FIN_PT: n_state = S_FIN_PF;
            S_FIN_PF: n_state = S_FIN_PU;
            S_FIN_PU: n_state = S_NORM;
            S_NORM:   n_state = S_DIV_CHK;
            S_DIV_CHK, S_DIV: begin
                if ((r_state == S_DIV_CHK && i_stat.norm_zero) ||
                    (r_state == S_DIV && i_stat.div_done)) begin
                    n_ost   = (r_state == S_DIV) ? ST_OK : ST_ZERO_NORM;
                    n_oval  = (r_state == S_DIV) ? VAL_QUOT : VAL_ZERO;
                    n_state = S_OUT;
                    if (r_emit) begin
                        n_ocl   = CL_DEST;
                        n_olast = emit_last;
                        n_ret   = emit_last ? S_IDLE : S_EM_RD;
                        n_k     = r_k + 1'b1;
                        n_i     = r_i + 1'b1;
                    end
                end else begin
                    n_state = S_DIV;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) n_state = r_ret;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd             = '0;
        o_cmd.wr_sel      = WR_NEW;
        o_cmd.mul_op      = MUL_NONE;
        o_cmd.num_sel     = r_emit ? (r_pass ? NUM_PT : NUM_PF) : NUM_DIFF;
        o_cmd.out_status  = r_ost;
        o_cmd.out_cl      = r_ocl;
        o_cmd.out_val     = r_oval;
        o_cmd.out_changed = r_ochg;
        o_cmd.out_last    = r_olast;
        o_cmd.use_excl    = r_emit;
        o_ready           = (r_state == S_IDLE);
        case (r_state)
            S_IDLE: begin
                o_cmd.lat_req   = accept;
                o_cmd.prod_init = accept && (i_req_type == REQ_BIAS);
            end
            S_ADD: begin
                o_cmd.wr_en   = (r_cnt != CNT_W'(MAX_CONN));
                o_cmd.wr_addr = r_cnt[ADDR_W-1:0];
                o_cmd.wr_sel  = WR_NEW;
            end
            S_RM_RD, S_UP_RD, S_EM_RD: begin
                o_cmd.rd_en   = (r_i != r_cnt);
                o_cmd.rd_addr = r_i[ADDR_W-1:0];
            end
            S_RM_CHK: begin
                o_cmd.wr_en   = !i_stat.match;
                o_cmd.wr_addr = r_w[ADDR_W-1:0];
                o_cmd.wr_sel  = WR_COPY;
            end
            S_UP_CHK: begin
                o_cmd.wr_en   = i_stat.match && i_stat.big;
                o_cmd.wr_addr = r_i[ADDR_W-1:0];
                o_cmd.wr_sel  = WR_SURV;
            end
            S_EM_DEST: begin
                o_cmd.lat_dest  = (i_stat.rd_neg == r_pass);
                o_cmd.prod_init = (i_stat.rd_neg == r_pass);
            end
            S_PW_RD: begin
                o_cmd.rd_en   = (r_j != r_cnt);
                o_cmd.rd_addr = r_j[ADDR_W-1:0];
            end
            S_PW_MUL:  o_cmd.mul_op    = MUL_STEP;
            S_FIN_PT:  o_cmd.mul_op    = MUL_PT;
            S_FIN_PF:  o_cmd.mul_op    = MUL_PF;
            S_FIN_PU:  o_cmd.mul_op    = MUL_PU;
            S_NORM:    o_cmd.norm_load = 1'b1;
            S_DIV_CHK: o_cmd.div_start = !i_stat.norm_zero;
            S_OUT:     o_cmd.out_load  = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
            r_cnt   <= n_cnt;
        end
        r_i <= n_i; r_j <= n_j; r_w <= n_w; r_k <= n_k;
        r_pass <= n_pass; r_emit <= n_emit; r_removed <= n_removed;
        r_ost <= n_ost; r_ocl <= n_ocl; r_oval <= n_oval;
        r_ochg <= n_ochg; r_olast <= n_olast;
    end

endmodule

>>> sv/spvn_dp.sv
module spvn_dp
    import spvn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [Q_W-1:0]   i_cfg_wdata,
    input  logic [CID_W-1:0] i_clause_id,
    input  logic             i_negative_list,
    input  logic [Q_W-1:0]   i_survey_value,
    input  t_cmd             i_cmd,
    input  logic             i_out_ready,
    output t_stat            o_stat,
    output logic             o_out_valid,
    output logic [2:0]       o_status,
    output logic [CID_W-1:0] o_target_clause,
    output logic             o_target_negative,
    output logic [Q_W-1:0]   o_result_value,
    output logic             o_changed,
    output logic             o_last
);

    t_entry             mem [MAX_CONN];
    t_entry             r_rd, r_dest, wdata;
    logic [CID_W-1:0]   r_cid;
    logic               r_neg;
    logic [Q_W-1:0]     r_sv, r_thr, diff, quot;
    logic [P_W-1:0]     r_pp, r_pn, r_pt, r_pf, r_pu, mul_a, mul_b, mul_res, num;
    logic [2*P_W-1:0]   product;
    logic [N_W-1:0]     r_norm, r_rem;
    logic [N_W:0]       shifted;
    logic [P_W-1:0]     r_q;
    logic [DCNT_W-1:0]  r_dv_cnt;
    logic               r_dv_first, excluded, r_ovalid;

    assign diff = (r_rd.survey > r_sv) ? (r_rd.survey - r_sv) : (r_sv - r_rd.survey);

    always_comb begin
        wdata = r_rd;
        case (i_cmd.wr_sel)
            WR_NEW:  wdata = '{clause: r_cid, neg: r_neg, survey: '0};
            WR_COPY: wdata = r_rd;
            WR_SURV: wdata = '{clause: r_rd.clause, neg: r_rd.neg, survey: r_sv};
            default: wdata = r_rd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) mem[i_cmd.wr_addr] <= wdata;
        if (i_cmd.rd_en) r_rd <= mem[i_cmd.rd_addr];
    end

    // Shared 17x17 multiplier; each product is truncated back to Q1.16.
    always_comb begin
        mul_a = r_pp;
        mul_b = ONE_Q16 - P_W'(r_rd.survey);
        case (i_cmd.mul_op)
            MUL_STEP: mul_a = r_rd.neg ? r_pn : r_pp;
            MUL_PT: begin
                mul_a = r_pn;
                mul_b = ONE_Q16 - r_pp;
            end
            MUL_PF: begin
                mul_a = r_pp;
                mul_b = ONE_Q16 - r_pn;
            end
            MUL_PU: begin
                mul_a = r_pn;
                mul_b = r_pp;
            end
            default: ;
        endcase
    end

    assign product  = mul_a * mul_b;
    assign mul_res  = product[P_W+Q_W-1:Q_W];
    assign excluded = i_cmd.use_excl && (r_rd.clause == r_dest.clause);

    always_comb begin
        case (i_cmd.num_sel)
            NUM_PF:  num = r_pf;
            NUM_PT:  num = r_pt;
            NUM_DIFF: num = (r_pt > r_pf) ? (r_pt - r_pf) : (r_pf - r_pt);
            default: num = r_pf;
        endcase
    end

    assign shifted = r_dv_first ? {1'b0, r_rem} : {r_rem, 1'b0};
    assign quot    = r_q[P_W-1] ? SAT_Q16 : r_q[Q_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_req) begin
            r_cid <= i_clause_id;
            r_neg <= i_negative_list;
            r_sv  <= i_survey_value;
        end
        if (i_cmd.lat_dest) r_dest <= r_rd;
        if (i_cmd.prod_init) begin
            r_pp <= ONE_Q16;
            r_pn <= ONE_Q16;
        end
        case (i_cmd.mul_op)
            MUL_STEP: begin
                if (!excluded) begin
                    if (r_rd.neg) r_pn <= mul_res;
                    else          r_pp <= mul_res;
                end
            end
            MUL_PT:  r_pt <= mul_res;
            MUL_PF:  r_pf <= mul_res;
            MUL_PU:  r_pu <= mul_res;
            default: ;
        endcase
        if (i_cmd.norm_load) r_norm <= N_W'(r_pt) + N_W'(r_pf) + N_W'(r_pu);
        if (i_cmd.div_start) begin
            r_rem      <= N_W'(num);
            r_q        <= '0;
            r_dv_first <= 1'b1;
        end else if (r_dv_cnt != '0) begin
            r_dv_first <= 1'b0;
            if (shifted >= {1'b0, r_norm}) begin
                r_rem <= N_W'(shifted - {1'b0, r_norm});
                r_q   <= {r_q[P_W-2:0], 1'b1};
            end else begin
                r_rem <= N_W'(shifted);
                r_q   <= {r_q[P_W-2:0], 1'b0};
            end
        end
        if (i_cmd.out_load) begin
            o_status          <= i_cmd.out_status;
            o_changed         <= i_cmd.out_changed;
            o_last            <= i_cmd.out_last;
            case (i_cmd.out_cl)
                CL_REQ: begin
                    o_target_clause   <= r_cid;
                    o_target_negative <= r_neg;
                end
                CL_DEST: begin
                    o_target_clause   <= r_dest.clause;
                    o_target_negative <= r_dest.neg;
                end
                default: begin
                    o_target_clause   <= '0;
                    o_target_negative <= 1'b0;
                end
            endcase
            case (i_cmd.out_val)
                VAL_SURV: o_result_value <= i_cmd.out_changed ? r_sv : r_rd.survey;
                VAL_QUOT: o_result_value <= quot;
                default:  o_result_value <= '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr    <= THR_RESET;
            r_dv_cnt <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) r_thr <= i_cfg_wdata;
            if (i_cmd.div_start)     r_dv_cnt <= DCNT_W'(DIV_STEPS);
            else if (r_dv_cnt != '0) r_dv_cnt <= r_dv_cnt - 1'b1;
            if (i_cmd.out_load)      r_ovalid <= 1'b1;
            else if (i_out_ready)    r_ovalid <= 1'b0;
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_stat.match     = (r_rd.clause == r_cid) && (r_rd.neg == r_neg);
    assign o_stat.rd_neg    = r_rd.neg;
    assign o_stat.big       = (diff > r_thr);
    assign o_stat.norm_zero = (r_norm == '0);
    assign o_stat.div_done  = (r_dv_cnt == '0);
    assign o_stat.out_free  = !r_ovalid || i_out_ready;

endmodule

>>> sv/spvn_checker.sv
module spvn_checker
    import spvn_pkg::*;
(
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_req_valid,
    input logic           i_req_ready,
    input logic           i_res_valid,
    input logic           i_res_ready,
    input logic [2:0]     i_status,
    input logic [Q_W-1:0] i_value,
    input logic           i_changed,
    input logic           i_last
);

    // A held result word stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result word dropped while stalled");

    // Only one request is in work at a time.
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in work");

    // Any error status carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_status != ST_OK) |-> (i_value == '0))
        else $error("error word with nonzero value");

    // A changed flag comes only on a single successful update word.
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_changed) |-> (i_status == ST_OK && i_last))
        else $error("changed flag on wrong word");

endmodule

bind survey_propagation_variable_node spvn_checker u_spvn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_status    (o_res.status),
    .i_value     (o_res.result_value),
    .i_changed   (o_res.changed),
    .i_last      (o_res.last)
);

>>> tb/spvn_tb_pkg.sv
`timescale 1ns / 100ps
package spvn_tb_pkg;
    import spvn_pkg::*;

    typedef struct packed {
        logic [2:0]       req_type;
        logic [CID_W-1:0] clause_id;
        logic             negative_list;
        logic [Q_W-1:0]   survey_value;
    } t_req_word;

    typedef struct packed {
        logic [2:0]       status;
        logic [CID_W-1:0] target_clause;
        logic             target_negative;
        logic [Q_W-1:0]   result_value;
        logic             changed;
        logic             last;
    } t_res_word;
endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import spvn_pkg::*;
    import spvn_tb_pkg::*;

    // A queued entry is either a request or a pause; a pause holds the sender
    // until all results are in and then writes the threshold in its survey field.
    typedef struct packed {
        logic      pause;
        t_req_word req;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [Q_W-1:0] i_cfg_wdata = '0;

    spvn_req_if req_ch();
    spvn_res_if res_ch();

    survey_propagation_variable_node dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_req(req_ch.sink), .o_res(res_ch.source)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: the connection table kept compact in insertion order.
    logic [CID_W-1:0] node_clause [MAX_CONN];
    logic             node_neg    [MAX_CONN];
    logic [Q_W-1:0]   node_survey [MAX_CONN];
    int               node_count;
    logic [Q_W-1:0]   node_threshold;

    t_stim     pending_reqs[$];
    t_res_word expected_words[$];
    int  mismatches = 0;
    int  words_seen = 0;
    int  reqs_sent = 0;
    int  pauses_done = 0;
    int  status_seen [8];
    bit  hold_sink = 1'b0;

    function automatic t_res_word mk_word(logic [2:0] st, logic [CID_W-1:0] cl,
                                          logic ng, logic [Q_W-1:0] v,
                                          logic ch, logic lst);
        t_res_word w;
        w.status = st;
        w.target_clause = cl;
        w.target_negative = ng;
        w.result_value = v;
        w.changed = ch;
        w.last = lst;
        return w;
    endfunction

    task automatic expect_word(input t_res_word w);
        expected_words = {expected_words, w};
    endtask

    // Products of (1-survey) per polarity, optionally skipping one clause id, and pt, pf, norm from them.
    task automatic node_probs(input bit skip, input logic [CID_W-1:0] skip_id,
                              output logic [63:0] pt, output logic [63:0] pf,
                              output logic [63:0] norm);
        logic [63:0] pp, pn, f, pu;
        pp = 64'h10000;
        pn = 64'h10000;
        for (int j = 0; j < node_count; j++) begin
            if (!(skip && node_clause[j] == skip_id)) begin
                f = 64'h10000 - node_survey[j];
                if (node_neg[j]) begin
                    pn = (pn * f) >> 16;
                end else begin
                    pp = (pp * f) >> 16;
                end
            end
        end
        pt = (pn * (64'h10000 - pp)) >> 16;
        pf = (pp * (64'h10000 - pn)) >> 16;
        pu = (pn * pp) >> 16;
        norm = pt + pf + pu;
    endtask

    function automatic logic [Q_W-1:0] sat_quot(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        q = (num << 16) / den;
        return (q > 64'hFFFF) ? SAT_Q16 : q[Q_W-1:0];
    endfunction

    // Applies one accepted request to the predictor and queues its result words.
    task automatic predict_request(input t_req_word r);
        int w, removed, k;
        logic [Q_W-1:0] d;
        logic [63:0] pt, pf, norm, dif;
        bit found;
        case (r.req_type)
            REQ_ADD: begin
                if (node_count >= MAX_CONN) begin
                    expect_word(mk_word(ST_FULL, r.clause_id, r.negative_list,
                                        '0, 1'b0, 1'b1));
                end else begin
                    node_clause[node_count] = r.clause_id;
                    node_neg[node_count] = r.negative_list;
                    node_survey[node_count] = '0;
                    node_count++;
                    expect_word(mk_word(ST_OK, r.clause_id, r.negative_list,
                                        '0, 1'b0, 1'b1));
                end
            end
            REQ_REMOVE: begin
                w = 0;
                removed = 0;
                for (int i = 0; i < node_count; i++) begin
                    if (node_clause[i] == r.clause_id && node_neg[i] == r.negative_list) begin
                        removed++;
                    end else begin
                        node_clause[w] = node_clause[i];
                        node_neg[w] = node_neg[i];
                        node_survey[w] = node_survey[i];
                        w++;
                    end
                end
                node_count = w;
                expect_word(mk_word((removed == 1) ? ST_OK : ST_NOT_FOUND,
                                    r.clause_id, r.negative_list, '0, 1'b0, 1'b1));
            end
            REQ_UPDATE: begin
                found = 1'b0;
                for (int i = 0; i < node_count && !found; i++) begin
                    if (node_clause[i] == r.clause_id && node_neg[i] == r.negative_list) begin
                        found = 1'b1;
                        d = (node_survey[i] > r.survey_value) ?
                            node_survey[i] - r.survey_value : r.survey_value - node_survey[i];
                        if (d > node_threshold) begin
                            node_survey[i] = r.survey_value;
                        end
                        expect_word(mk_word(ST_OK, r.clause_id, r.negative_list,
                                            node_survey[i], d > node_threshold, 1'b1));
                    end
                end
                if (!found) begin
                    expect_word(mk_word(ST_NOT_FOUND, r.clause_id, r.negative_list,
                                        '0, 1'b0, 1'b1));
                end
            end
            REQ_EMIT: begin
                if (node_count == 0) begin
                    expect_word(mk_word(ST_NO_CONN, '0, 1'b0, '0, 1'b0, 1'b1));
                end else begin
                    k = 0;
                    // Positive destinations first, then negative, each in table order.
                    for (int pass = 0; pass < 2; pass++) begin
                        for (int i = 0; i < node_count; i++) begin
                            if (node_neg[i] == pass) begin
                                node_probs(1'b1, node_clause[i], pt, pf, norm);
                                k++;
                                if (norm == 0) begin
                                    expect_word(mk_word(ST_ZERO_NORM, node_clause[i],
                                        node_neg[i], '0, 1'b0, k == node_count));
                                end else begin
                                    expect_word(mk_word(ST_OK, node_clause[i],
                                        node_neg[i], sat_quot(pass ? pt : pf, norm),
                                        1'b0, k == node_count));
                                end
                            end
                        end
                    end
                end
            end
            REQ_BIAS: begin
                node_probs(1'b0, '0, pt, pf, norm);
                if (norm == 0) begin
                    expect_word(mk_word(ST_ZERO_NORM, r.clause_id, r.negative_list,
                                        '0, 1'b0, 1'b1));
                end else begin
                    dif = (pt > pf) ? pt - pf : pf - pt;
                    expect_word(mk_word(ST_OK, r.clause_id, r.negative_list,
                                        sat_quot(dif, norm), 1'b0, 1'b1));
                end
            end
            default: begin
                // Unknown request types are echoed back with status ok.
                expect_word(mk_word(ST_OK, r.clause_id, r.negative_list,
                                    '0, 1'b0, 1'b1));
            end
        endcase
    endtask

    // Driver: bursts of random length separated by random gaps. A pause entry
    // holds the sender until every expected word has arrived, then writes the
    // threshold while the block is idle.
    int burst_left = 0;
    int gap_left = 0;
    t_req_word cur_word;
    t_stim cur_stim;
    bit cfg_now;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.req_type <= '0;
            req_ch.clause_id <= '0;
            req_ch.negative_list <= 1'b0;
            req_ch.survey_value <= '0;
            i_cfg_we <= 1'b0;
        end else begin
            cfg_now = 1'b0;
            if (req_ch.valid && req_ch.ready) begin
                cur_word.req_type = req_ch.req_type;
                cur_word.clause_id = req_ch.clause_id;
                cur_word.negative_list = req_ch.negative_list;
                cur_word.survey_value = req_ch.survey_value;
                predict_request(cur_word);
                reqs_sent++;
            end
            if (!(req_ch.valid && !req_ch.ready)) begin
                if (pending_reqs.size() > 0 && pending_reqs[0].pause) begin
                    req_ch.valid <= 1'b0;
                    if (expected_words.size() == 0 && !(req_ch.valid && req_ch.ready) &&
                        !i_cfg_we) begin
                        cur_stim = pending_reqs.pop_front();
                        cfg_now = 1'b1;
                        i_cfg_wdata <= cur_stim.req.survey_value;
                        node_threshold = cur_stim.req.survey_value;
                        pauses_done++;
                    end
                end else if (pending_reqs.size() > 0 && gap_left == 0) begin
                    cur_stim = pending_reqs.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.req_type <= cur_stim.req.req_type;
                    req_ch.clause_id <= cur_stim.req.clause_id;
                    req_ch.negative_list <= cur_stim.req.negative_list;
                    req_ch.survey_value <= cur_stim.req.survey_value;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 12);
                    end
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
                    end
                end else begin
                    req_ch.valid <= 1'b0;
                    if (gap_left > 0) begin
                        gap_left--;
                    end
                end
            end
            i_cfg_we <= cfg_now;
        end
    end

    // Receiver stall pattern: alternating ready and stall runs.
    int stall_run = 0;
    bit stall_state = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_state = ~stall_state;
                stall_run = stall_state ? $urandom_range(1, 6) :
                            (($urandom_range(0, 4) == 0) ? 200 : $urandom_range(2, 30));
            end
            stall_run--;
            res_ch.ready <= !hold_sink && !stall_state;
        end
    end

    // One long receiver hold partway through, while the sender keeps offering.
    int hold_count = 0;
    bit hold_done = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_sink <= 1'b0;
            hold_count <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && reqs_sent >= 150) begin
            hold_sink <= 1'b1;
            hold_count <= 600;
            hold_done <= 1'b1;
        end else if (hold_count > 0) begin
            hold_count <= hold_count - 1;
            if (hold_count == 1) begin
                hold_sink <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted word against the oldest expectation.
    t_res_word want, got;
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            words_seen++;
            got.status = res_ch.status;
            got.target_clause = res_ch.target_clause;
            got.target_negative = res_ch.target_negative;
            got.result_value = res_ch.result_value;
            got.changed = res_ch.changed;
            got.last = res_ch.last;
            status_seen[got.status]++;
            if (expected_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result word: status %0d clause %0h value %0h",
                             got.status, got.target_clause, got.result_value);
                end
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected st %0d cl %0h neg %0b val %0h ch %0b last %0b",
                                 want.status, want.target_clause, want.target_negative,
                                 want.result_value, want.changed, want.last);
                        $display("          actual   st %0d cl %0h neg %0b val %0h ch %0b last %0b",
                                 got.status, got.target_clause, got.target_negative,
                                 got.result_value, got.changed, got.last);
                    end
                end
            end
        end
    end

    // Stimulus: about 400 requests over a small clause set so that matches,
    // duplicates, a full table and zero normalisers all come up, with a pause
    // and a new threshold after every hundred requests.
    initial begin
        t_stim s;
        int sel;
        logic [Q_W-1:0] thr_list [4];
        thr_list[0] = 16'd0;
        thr_list[1] = 16'hFFFF;
        thr_list[2] = 16'd1000;
        thr_list[3] = THR_RESET;
        node_count = 0;
        node_threshold = THR_RESET;
        for (int st = 0; st < 8; st++) begin
            status_seen[st] = 0;
        end
        for (int n = 0; n < 400; n++) begin
            s = '0;
            sel = $urandom_range(0, 99);
            if (n == 0) begin
                s.req.req_type = REQ_EMIT;
            end else if (n == 1) begin
                s.req.req_type = REQ_BIAS;
            end else if (n >= 40 && n < 80) begin
                s.req.req_type = REQ_ADD;
            end else if (sel < 35) begin
                s.req.req_type = REQ_ADD;
            end else if (sel < 47) begin
                s.req.req_type = REQ_REMOVE;
            end else if (sel < 72) begin
                s.req.req_type = REQ_UPDATE;
            end else if (sel < 80) begin
                s.req.req_type = REQ_EMIT;
            end else if (sel < 94) begin
                s.req.req_type = REQ_BIAS;
            end else begin
                s.req.req_type = 3'($urandom_range(5, 7));
            end
            s.req.clause_id = ($urandom_range(0, 9) == 0) ? CID_W'($urandom()) :
                              CID_W'($urandom_range(0, 11));
            s.req.negative_list = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 4))
                0:       s.req.survey_value = 16'd0;
                1:       s.req.survey_value = 16'hFFFF;
                2:       s.req.survey_value = 16'hFFFE;
                3:       s.req.survey_value = Q_W'($urandom_range(0, 200));
                default: s.req.survey_value = Q_W'($urandom());
            endcase
            pending_reqs = {pending_reqs, s};
            if (n % 100 == 99) begin
                s = '0;
                s.pause = 1'b1;
                s.req.survey_value = thr_list[n / 100];
                pending_reqs = {pending_reqs, s};
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
            #1;
        end while (pending_reqs.size() != 0 || req_ch.valid || i_cfg_we ||
                   expected_words.size() != 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d requests, %0d result words, %0d threshold writes",
                 reqs_sent, words_seen, pauses_done);
        $display("words by status: ok %0d, not found %0d, full %0d, zero norm %0d, empty %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("timeout with %0d words outstanding", expected_words.size());
        $display("end of test: mismatches");
        $finish;
    end
endmodule

>>> filelist.f
sv/spvn_pkg.sv
sv/spvn_if.sv
sv/spvn_ctrl.sv
sv/spvn_dp.sv
sv/survey_propagation_variable_node.sv
sv/spvn_checker.sv
tb/spvn_tb_pkg.sv
tb/tb_top.sv
